### rtl/bpl_pkg.sv
// Shared types and constants for the bit-to-pulse-level packer.
// Standalone package; used by every module of the block.
package bpl_pkg;

	// Item codes
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// Line code and packing constants
	localparam int unsigned LEVELS_PER_BYTE = 8;
	localparam int unsigned MAX_LEVELS      = 24;
	localparam logic [7:0]  PAD_ONES        = 8'hFF;

	// Queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	// Classified item: levels left-aligned, first level in bit 23
	typedef struct packed {
		logic        action;
		logic [23:0] levels;
		logic [4:0]  len;
	} entry_t;

endpackage

### rtl/bpl_front.sv
// Front part: accepts items and line-codes data bytes into level words.
// Depends on bpl_pkg.
module bpl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  bpl_pkg::item_t item,
	output logic           push_valid,
	input  logic           push_ready,
	output bpl_pkg::entry_t push_entry
);
	import bpl_pkg::*;

	logic   valid_s1;
	entry_t entry_s1;
	entry_t entry_d;
	logic   advance;

	// One is 1,0; zero is 1,0,0; first level toward bit 23
	function automatic entry_t encode(item_t it);
		entry_t     e;
		logic [4:0] pos;
		e.action = it.action;
		e.levels = '0;
		pos = 5'(MAX_LEVELS);
		for (int i = 7; i >= 0; i--) begin
			e.levels[pos - 5'd1] = 1'b1;
			pos = pos - 5'd2;
			if (!it.data_byte[i]) begin
				pos = pos - 5'd1;
			end
		end
		e.len = 5'(MAX_LEVELS) - pos;
		return e;
	endfunction

	assign entry_d    = encode(item);
	assign advance    = !valid_s1 || push_ready;
	assign item_stall = !advance;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

### rtl/bpl_queue.sv
// Short queue of classified items between front and back.
// Depends on bpl_pkg.
module bpl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  bpl_pkg::entry_t push_entry,
	output logic            head_valid,
	input  logic            pop,
	output bpl_pkg::entry_t head_entry
);
	import bpl_pkg::*;

	entry_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_entry = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

### rtl/bpl_back.sv
// Back part: merges leftover levels with each item and emits packed bytes.
// Depends on bpl_pkg.
module bpl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  bpl_pkg::entry_t  head_entry,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output bpl_pkg::result_t result
);
	import bpl_pkg::*;

	// Level window, oldest level in bit 31; total_q counts valid levels.
	logic [31:0] shreg_q;
	logic [4:0]  total_q;
	logic        res_valid_q;
	result_t     res_q;

	logic        has_byte;
	logic        adv;
	logic        emit;
	logic        free;
	logic [7:0]  rem;
	logic [2:0]  rcnt;
	logic [31:0] load_shreg;
	logic [4:0]  load_total;

	assign has_byte = total_q[4:3] != 2'b00;
	assign adv      = !res_valid_q || !result_stall;
	assign emit     = adv && has_byte;
	assign free     = !has_byte || (emit && !total_q[4]);
	assign pop      = head_valid && free;

	// Leftover levels once the current window is drained
	assign rem  = has_byte ? shreg_q[23:16] : shreg_q[31:24];
	assign rcnt = total_q[2:0];

	always_comb begin
		if (head_entry.action == ACT_FLUSH) begin
			if (rcnt == 3'd0) begin
				load_shreg = '0;
				load_total = '0;
			end else begin
				load_shreg = {rem | (PAD_ONES >> rcnt), 24'b0};
				load_total = 5'(LEVELS_PER_BYTE);
			end
		end else begin
			load_shreg = {rem, 24'b0} | ({head_entry.levels, 8'b0} >> rcnt);
			load_total = {2'b00, rcnt} + head_entry.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shreg_q     <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				shreg_q <= load_shreg;
				total_q <= load_total;
			end else if (emit) begin
				shreg_q <= {shreg_q[23:0], 8'b0};
				total_q <= total_q - 5'(LEVELS_PER_BYTE);
			end
			if (adv) begin
				res_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_byte <= shreg_q[31:24];
			res_q.last     <= !total_q[4];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### rtl/bit_to_pulse_level_packer_top.sv
// Top level of the bit-to-pulse-level packer.
// Depends on bpl_pkg, bpl_front, bpl_queue and bpl_back.
//
//  channel  dir  handshake                   payload
//  item     in   item_valid / item_stall     item_t   {action, data_byte}
//  result   out  result_valid / result_stall result_t {out_byte, last}
//
// An encode item yields two or three output bytes; a flush yields one
// byte or none. The back part emits one output byte per cycle unless
// result_stall holds it, which sets the rate. With the queue empty, an
// item passes the front register, a queue slot and the level window
// before the result register holds its first byte.
// Reset clears all pending levels and empties the queue.
// A stalled result holds the back part; the queue then fills and the front
// raises item_stall.
module bit_to_pulse_level_packer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bpl_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output bpl_pkg::result_t result
);
	import bpl_pkg::*;

	// Front to queue
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;

	// Queue to back
	logic   head_valid;
	logic   pop;
	entry_t head_entry;

	// Classify and line-code each item
	bpl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Decouple front and back so each may stall on its own
	bpl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.pop        (pop),
		.head_entry (head_entry)
	);

	// Pack levels and transfer bytes out
	bpl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### rtl/bpl_checker.sv
// Port-level checks for the packer top level, attached by bind.
// Depends on bpl_pkg and bit_to_pulse_level_packer_top.
module bpl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input bpl_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input bpl_pkg::result_t result
);
	import bpl_pkg::*;

	// Count transfers since the last byte that closed an item
	logic [1:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (result_valid && !result_stall) begin
			run_q <= result.last ? 2'd0 : run_q + 2'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	a_max_three: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && run_q == 2'd2 |-> result.last)
		else $error("more than three bytes for one item");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("item dropped or changed while stalled");

endmodule

bind bit_to_pulse_level_packer_top bpl_checker u_bpl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
